>>> hdl/iqoc_pkg.sv
`timescale 1ns / 1ps
package iqoc_pkg;

    localparam int QUAT_BITS_DEF = 16;
    localparam int TICK_BITS     = 20;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 20;

    localparam logic [CFG_IDX_BITS-1:0] REG_WAIT  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_REF_X = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_REF_Y = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_REF_Z = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_REF_W = 3'd4;

    localparam logic [TICK_BITS-1:0] WAIT_RESET = 20'd5000;
    localparam logic [TICK_BITS-1:0] TICK_MAX   = '1;

    // Beat kinds.
    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef struct packed {
        logic                          func;
        logic signed [QUAT_BITS_DEF-1:0] sample_x;
        logic signed [QUAT_BITS_DEF-1:0] sample_y;
        logic signed [QUAT_BITS_DEF-1:0] sample_z;
        logic signed [QUAT_BITS_DEF-1:0] sample_w;
    } t_in_beat;

    typedef struct packed {
        logic signed [QUAT_BITS_DEF-1:0] out_x;
        logic signed [QUAT_BITS_DEF-1:0] out_y;
        logic signed [QUAT_BITS_DEF-1:0] out_z;
        logic signed [QUAT_BITS_DEF-1:0] out_w;
        logic                          just_calibrated;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_NORM_MAX,
        ST_NORM_SHIFT,
        ST_DONE,
        ST_OUT
    } t_state;

endpackage

>>> hdl/iqoc_norm.sv
`timescale 1ns / 1ps
// Sequential normalizer: shift to [2^29, 2^30), sum of squares, bit-serial
// square root, then one restoring divider shared by the four components.
module iqoc_norm #(
    parameter int QB = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [2*QB+1:0] i_v [4],
    output logic                 o_done,
    output logic signed [QB-1:0] o_r [4]
);
    import iqoc_pkg::*;

    localparam int VW = 2 * QB + 2;
    localparam int F  = QB - 2;
    localparam int SW = 64;
    localparam int NW = 32;
    localparam int DW = 30 + F + 1;
    localparam int CW = 7;

    typedef enum logic [2:0] {
        N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DIV, N_NEXT
    } t_nst;

    t_nst              r_st;
    logic [VW-1:0]     r_mag [4];
    logic [3:0]        r_neg;
    logic [1:0]        r_i;
    logic [SW-1:0]     r_s, r_rem, r_res, r_bit;
    logic [NW-1:0]     r_n;
    logic [DW-1:0]     r_num, r_q, r_dr;
    logic [CW-1:0]     r_cnt;
    logic              r_zero;

    logic [VW-1:0] w_or;
    logic [SW-1:0] w_trial, w_prod;
    logic [DW:0]   w_sub;
    logic [DW-1:0] w_qs;
    logic          w_fin;

    assign w_or    = r_mag[0] | r_mag[1] | r_mag[2] | r_mag[3];
    assign w_trial = r_res + r_bit;
    assign w_prod  = SW'(r_mag[r_i][29:0]) * SW'(r_mag[r_i][29:0]);
    assign w_sub   = {r_dr, r_num[DW-1]} - {1'b0, DW'(r_n)};
    assign w_qs    = (r_q > DW'(1 << F)) ? DW'(1 << F) : r_q;
    assign w_fin   = (r_st == N_NEXT && r_zero)
                  || (r_st == N_DIV && r_cnt == CW'(DW) && r_i == 2'd3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= N_IDLE;
            o_done <= 1'b0;
        end else begin
            o_done <= w_fin;
            unique case (r_st)
                N_IDLE: if (i_start) begin
                    for (int k = 0; k < 4; k++) begin
                        r_neg[k] <= i_v[k][VW-1];
                        r_mag[k] <= i_v[k][VW-1] ? VW'(-i_v[k]) : VW'(i_v[k]);
                    end
                    r_st <= N_SHIFT;
                end
                // One bit of shift per cycle until the largest sits in range.
                N_SHIFT: begin
                    if (w_or == '0) begin
                        r_zero <= 1'b1;
                        r_i <= 2'd0;
                        r_st <= N_NEXT;
                    end else if (|w_or[VW-1:30]) begin
                        for (int k = 0; k < 4; k++) r_mag[k] <= r_mag[k] >> 1;
                    end else if (!w_or[29]) begin
                        for (int k = 0; k < 4; k++) r_mag[k] <= r_mag[k] << 1;
                    end else begin
                        r_zero <= 1'b0;
                        r_s <= '0;
                        r_i <= 2'd0;
                        r_st <= N_SQ;
                    end
                end
                N_SQ: begin
                    r_s <= r_s + w_prod;
                    r_i <= r_i + 2'd1;
                    if (r_i == 2'd3) begin
                        r_rem <= r_s + w_prod;
                        r_res <= '0;
                        r_bit <= SW'(1) << 62;
                        r_st  <= N_SQRT;
                    end
                end
                N_SQRT: begin
                    if (r_rem >= w_trial) begin
                        r_rem <= r_rem - w_trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == SW'(1)) begin
                        r_i  <= 2'd0;
                        r_st <= N_NEXT;
                    end
                end
                N_NEXT: begin
                    if (r_zero) begin
                        for (int k = 0; k < 4; k++) o_r[k] <= '0;
                        r_st <= N_IDLE;
                    end else begin
                        r_n   <= NW'(r_res);
                        r_num <= (DW'(r_mag[r_i][29:0]) << F) + DW'(r_res[NW-1:1]);
                        r_dr  <= '0;
                        r_q   <= '0;
                        r_cnt <= '0;
                        r_st  <= N_DIV;
                    end
                end
                // The quotient is complete in the cycle after the last shift step.
                N_DIV: begin
                    if (r_cnt == CW'(DW)) begin
                        r_cnt <= '0;
                        o_r[r_i] <= r_neg[r_i] ? QB'(-$signed({1'b0, w_qs}))
                                               : QB'(w_qs);
                        r_i <= r_i + 2'd1;
                        r_st <= (r_i == 2'd3) ? N_IDLE : N_NEXT;
                    end else begin
                        if (!w_sub[DW]) begin
                            r_dr <= w_sub[DW-1:0];
                            r_q  <= {r_q[DW-2:0], 1'b1};
                        end else begin
                            r_dr <= {r_dr[DW-2:0], r_num[DW-1]};
                            r_q  <= {r_q[DW-2:0], 1'b0};
                        end
                        r_num <= r_num << 1;
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                default: r_st <= N_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_st) == N_NEXT || $past(r_st) == N_DIV)
        else $error("done outside final step");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == N_SQRT) |-> $onehot(r_bit) || r_bit == '0)
        else $error("sqrt bit not one-hot");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == N_SQ) |-> w_or[VW-1:30] == '0)
        else $error("magnitude out of range at square");
endmodule

>>> hdl/imu_quaternion_offset_calibrate_top.sv
`timescale 1ns / 1ps
// Orientation offset calibration.
// Input channel (i_in_valid/o_in_ready, payload t_in_beat): func 0 is a tick
// beat, func 1 an orientation sample in Q2.14. Configuration: i_cfg_we with
// i_cfg_idx/i_cfg_data writes wait_ticks (0) or ref x,y,z,w (1..4).
// Output channel (o_out_valid/i_out_ready, payload t_out_beat) carries the
// corrected normalized sample and a flag set on the calibrating sample.
// A sample that gives a result runs a Hamilton product on one shared
// multiplier, then the normalizer: shift, square, square-root and divider
// steps; the calibrating sample runs both passes. The next beat is taken
// the cycle after the result beat leaves.
// Reset clears the wait, calibration and tick count, sets the offset to the
// identity and the reference to a 90 degree yaw. A stalled result holds in
// the output register and the block takes no new beat until it leaves.
module imu_quaternion_offset_calibrate_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  iqoc_pkg::t_in_beat                     i_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output iqoc_pkg::t_out_beat                    o_out,
    input  logic                                   i_cfg_we,
    input  logic [iqoc_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [iqoc_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);
    import iqoc_pkg::*;

    localparam int QB = QUAT_BITS_DEF;
    localparam int VW = 2 * QB + 2;
    localparam logic signed [QB-1:0] ONE_Q   = QB'(1 << (QB - 2));
    localparam logic signed [QB-1:0] REF_DIA = 16'sd11585;

    t_state r_st, n_st;
    logic [TICK_BITS-1:0] r_wait, r_elapsed;
    logic signed [QB-1:0] r_ref [4], r_off [4], r_smp [4];
    logic r_started, r_cal, r_pass_cal;
    logic signed [QB-1:0] r_a [4], r_b [4];
    logic signed [VW-1:0] r_acc [4];
    logic [3:0] r_k;
    logic signed [2*QB-1:0] r_p;
    logic [1:0] r_pi;
    logic r_psub, r_pv, r_plast;
    logic w_nstart, w_ndone;
    logic signed [QB-1:0] w_nr [4];

    logic w_acc_in;
    assign w_acc_in = i_in_valid && o_in_ready;
    assign o_in_ready = (r_st == ST_IDLE) && !o_out_valid;

    // Hamilton term table: component, a index, b index, subtract.
    function automatic logic [6:0] f_term(input logic [3:0] k);
        logic [6:0] t;
        unique case (k)
            4'd0:  t = {2'd0, 2'd3, 2'd0, 1'b0};
            4'd1:  t = {2'd0, 2'd0, 2'd3, 1'b0};
            4'd2:  t = {2'd0, 2'd1, 2'd2, 1'b0};
            4'd3:  t = {2'd0, 2'd2, 2'd1, 1'b1};
            4'd4:  t = {2'd1, 2'd3, 2'd1, 1'b0};
            4'd5:  t = {2'd1, 2'd1, 2'd3, 1'b0};
            4'd6:  t = {2'd1, 2'd2, 2'd0, 1'b0};
            4'd7:  t = {2'd1, 2'd0, 2'd2, 1'b1};
            4'd8:  t = {2'd2, 2'd3, 2'd2, 1'b0};
            4'd9:  t = {2'd2, 2'd2, 2'd3, 1'b0};
            4'd10: t = {2'd2, 2'd0, 2'd1, 1'b0};
            4'd11: t = {2'd2, 2'd1, 2'd0, 1'b1};
            4'd12: t = {2'd3, 2'd3, 2'd3, 1'b0};
            4'd13: t = {2'd3, 2'd0, 2'd0, 1'b1};
            4'd14: t = {2'd3, 2'd1, 2'd1, 1'b1};
            default: t = {2'd3, 2'd2, 2'd2, 1'b1};
        endcase
        return t;
    endfunction

    logic [6:0] w_t;
    assign w_t = f_term(r_k);

    always_comb begin
        n_st = r_st;
        w_nstart = 1'b0;
        unique case (r_st)
            ST_IDLE:       if (w_acc_in && i_in.func == FUNC_SAMPLE && r_cal) n_st = ST_MUL;
            ST_MUL:        if (r_plast && r_pv) n_st = ST_NORM_MAX;
            ST_NORM_MAX:   begin w_nstart = 1'b1; n_st = ST_NORM_SHIFT; end
            ST_NORM_SHIFT: if (w_ndone) n_st = ST_DONE;
            ST_DONE:       n_st = r_pass_cal ? ST_MUL : ST_OUT;
            ST_OUT:        n_st = ST_IDLE;
            default:       n_st = ST_IDLE;
        endcase
        if (r_st == ST_IDLE && w_acc_in && i_in.func == FUNC_SAMPLE && !r_cal
            && r_started && r_elapsed >= r_wait) n_st = ST_MUL;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_wait <= WAIT_RESET;
            r_ref[0] <= '0; r_ref[1] <= '0; r_ref[2] <= REF_DIA; r_ref[3] <= REF_DIA;
            r_off[0] <= '0; r_off[1] <= '0; r_off[2] <= '0; r_off[3] <= ONE_Q;
            r_started <= 1'b0;
            r_cal <= 1'b0;
            r_elapsed <= '0;
            o_out_valid <= 1'b0;
            r_pass_cal <= 1'b0;
            r_k <= '0;
            r_pv <= 1'b0;
            r_psub <= 1'b0;
            r_plast <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_WAIT:  r_wait <= i_cfg_data;
                    REG_REF_X: r_ref[0] <= QB'(i_cfg_data);
                    REG_REF_Y: r_ref[1] <= QB'(i_cfg_data);
                    REG_REF_Z: r_ref[2] <= QB'(i_cfg_data);
                    REG_REF_W: r_ref[3] <= QB'(i_cfg_data);
                    default: ;
                endcase
            end
            if (r_st == ST_OUT) o_out_valid <= 1'b1;
            else if (o_out_valid && i_out_ready) o_out_valid <= 1'b0;
            if (r_st == ST_IDLE && w_acc_in) begin
                r_smp[0] <= i_in.sample_x; r_smp[1] <= i_in.sample_y;
                r_smp[2] <= i_in.sample_z; r_smp[3] <= i_in.sample_w;
                if (i_in.func == FUNC_TICK) begin
                    if (r_started && !r_cal && r_elapsed != TICK_MAX)
                        r_elapsed <= r_elapsed + TICK_BITS'(1);
                end else if (!r_started) begin
                    r_started <= 1'b1;
                    r_elapsed <= '0;
                end
                if (n_st == ST_MUL) begin
                    r_pass_cal <= !r_cal;
                    o_out.just_calibrated <= !r_cal;
                    // The conjugate is taken by flipping term signs, so the
                    // sample enters unchanged.
                    if (!r_cal) begin
                        r_a <= r_ref;
                    end else begin
                        r_a[0] <= i_in.sample_x; r_a[1] <= i_in.sample_y;
                        r_a[2] <= i_in.sample_z; r_a[3] <= i_in.sample_w;
                    end
                    if (!r_cal) begin
                        r_b[0] <= i_in.sample_x; r_b[1] <= i_in.sample_y;
                        r_b[2] <= i_in.sample_z; r_b[3] <= i_in.sample_w;
                    end else begin
                        r_b <= r_off;
                    end
                    for (int c = 0; c < 4; c++) r_acc[c] <= '0;
                    r_k <= '0; r_pv <= 1'b0; r_plast <= 1'b0;
                end
            end
            // One multiply per cycle; each product is registered and accumulated in the next cycle.
            if (r_st == ST_MUL) begin
                if (r_pv) begin
                    r_acc[r_pi] <= r_psub ? r_acc[r_pi] - VW'(r_p) : r_acc[r_pi] + VW'(r_p);
                end
                if (!r_plast) begin
                    r_p <= r_a[w_t[4:3]] * r_b[w_t[2:1]];
                    r_pi <= w_t[6:5];
                    r_psub <= w_t[0] ^ (r_pass_cal && w_t[2:1] != 2'd3);
                    r_pv <= 1'b1;
                    if (r_k == 4'd15) r_plast <= 1'b1;
                    else r_k <= r_k + 4'd1;
                end else begin
                    r_pv <= 1'b0;
                end
            end
            if (r_st == ST_DONE) begin
                if (r_pass_cal) begin
                    r_off <= w_nr;
                    r_cal <= 1'b1;
                    r_pass_cal <= 1'b0;
                    r_a <= r_smp;
                    r_b <= w_nr;
                    for (int c = 0; c < 4; c++) r_acc[c] <= '0;
                    r_k <= '0; r_pv <= 1'b0; r_plast <= 1'b0;
                end else begin
                    o_out.out_x <= w_nr[0]; o_out.out_y <= w_nr[1];
                    o_out.out_z <= w_nr[2]; o_out.out_w <= w_nr[3];
                end
            end
        end
    end

    iqoc_norm #(.QB(QB)) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_nstart),
        .i_v     (r_acc),
        .o_done  (w_ndone),
        .o_r     (w_nr)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_IDLE) |-> !o_in_ready)
        else $error("ready while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> r_cal)
        else $error("result before calibration");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cal && !$past(r_cal)) |-> $past(r_st) == ST_DONE)
        else $error("calibration outside done step");
endmodule

>>> tb/tb_imu_quaternion_offset_calibrate_top.sv
`timescale 1ns / 1ps
module tb_imu_quaternion_offset_calibrate_top;
    import iqoc_pkg::*;

    localparam int FRAC = 14;
    localparam longint ONE_Q = 64'sd1 << FRAC;
    localparam int SETTLE_CYCLES = 700;
    localparam int HOLD_CYCLES = 3000;
    localparam int RANDOM_ITEMS = 730;
    // Indexes that map to no register; writes to them must change nothing.
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

    class calib_scoreboard;
        longint unsigned wait_ticks;
        longint ref_q[4];
        bit wait_started;
        bit is_calibrated;
        longint unsigned elapsed;
        longint offset_q[4];
        t_out_beat pending[$];
        int errors;

        function new();
            wait_ticks = 5000;
            ref_q = '{0, 0, 11585, 11585};
            wait_started = 0;
            is_calibrated = 0;
            elapsed = 0;
            offset_q = '{0, 0, 0, ONE_Q};
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            logic signed [15:0] v;
            v = data[15:0];
            case (idx)
                REG_WAIT: wait_ticks = data;
                REG_REF_X: ref_q[0] = v;
                REG_REF_Y: ref_q[1] = v;
                REG_REF_Z: ref_q[2] = v;
                REG_REF_W: ref_q[3] = v;
                default: ;
            endcase
        endfunction

        function void hamilton(longint a[4], longint b[4], output longint r[4]);
            r[0] = a[3]*b[0] + a[0]*b[3] + a[1]*b[2] - a[2]*b[1];
            r[1] = a[3]*b[1] + a[1]*b[3] + a[2]*b[0] - a[0]*b[2];
            r[2] = a[3]*b[2] + a[2]*b[3] + a[0]*b[1] - a[1]*b[0];
            r[3] = a[3]*b[3] - a[0]*b[0] - a[1]*b[1] - a[2]*b[2];
        endfunction

        function longint unsigned int_sqrt(longint unsigned s);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > s) bitv >>= 2;
            while (bitv != 0) begin
                if (s >= res + bitv) begin
                    s -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        function void normalize(longint v[4], output longint r[4]);
            longint unsigned mag[4];
            longint unsigned m, s, n, q;
            bit neg[4];
            m = 0;
            s = 0;
            for (int i = 0; i < 4; i++) begin
                neg[i] = v[i] < 0;
                mag[i] = neg[i] ? -v[i] : v[i];
                if (mag[i] > m) m = mag[i];
            end
            if (m == 0) begin
                r = '{0, 0, 0, 0};
                return;
            end
            // Bring the largest magnitude into [2^29, 2^30) before the root.
            while (m >= (64'd1 << 30)) begin
                m >>= 1;
                for (int i = 0; i < 4; i++) mag[i] >>= 1;
            end
            while (m < (64'd1 << 29)) begin
                m <<= 1;
                for (int i = 0; i < 4; i++) mag[i] <<= 1;
            end
            for (int i = 0; i < 4; i++) s += mag[i] * mag[i];
            n = int_sqrt(s);
            for (int i = 0; i < 4; i++) begin
                q = ((mag[i] << FRAC) + (n >> 1)) / n;
                if (q > ONE_Q) q = ONE_Q;
                r[i] = neg[i] ? -longint'(q) : longint'(q);
            end
        endfunction

        function void note_input(t_in_beat b);
            longint smp[4], cj[4], tmp[4], res[4];
            t_out_beat e;
            bit just;
            just = 0;
            if (b.func == FUNC_TICK) begin
                if (wait_started && !is_calibrated && elapsed < TICK_MAX) elapsed++;
                return;
            end
            smp = '{b.sample_x, b.sample_y, b.sample_z, b.sample_w};
            if (!is_calibrated) begin
                if (!wait_started) begin
                    wait_started = 1;
                    elapsed = 0;
                    return;
                end
                if (elapsed < wait_ticks) return;
                cj = '{-smp[0], -smp[1], -smp[2], smp[3]};
                hamilton(ref_q, cj, tmp);
                normalize(tmp, offset_q);
                is_calibrated = 1;
                just = 1;
            end
            hamilton(smp, offset_q, tmp);
            normalize(tmp, res);
            e.out_x = res[0][15:0];
            e.out_y = res[1][15:0];
            e.out_z = res[2][15:0];
            e.out_w = res[3][15:0];
            e.just_calibrated = just;
            pending.push_back(e);
        endfunction

        function void check_result(t_out_beat got);
            t_out_beat e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected result beat %p", got);
                return;
            end
            e = pending.pop_front();
            if (got.out_x !== e.out_x || got.out_y !== e.out_y || got.out_z !== e.out_z ||
                got.out_w !== e.out_w || got.just_calibrated !== e.just_calibrated) begin
                errors++;
                if (errors <= 10)
                    $display("Mismatch: expected %0d %0d %0d %0d cal %0d, got %0d %0d %0d %0d cal %0d",
                             e.out_x, e.out_y, e.out_z, e.out_w, e.just_calibrated,
                             got.out_x, got.out_y, got.out_z, got.out_w, got.just_calibrated);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in_beat i_in;
    logic o_out_valid;
    logic i_out_ready;
    t_out_beat o_out;
    logic i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    calib_scoreboard sb;
    bit calm;
    bit hold_req;

    imu_quaternion_offset_calibrate_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #6000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int idle_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    task automatic send(t_in_beat b);
        int gap;
        gap = idle_len();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in <= b;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(b);
    endtask

    task automatic send_tick();
        t_in_beat b;
        b = {FUNC_TICK, 64'($urandom) ^ (64'($urandom) << 32)};
        send(b);
    endtask

    task automatic send_sample(int x, int y, int z, int w);
        t_in_beat b;
        b.func = FUNC_SAMPLE;
        b.sample_x = 16'(x);
        b.sample_y = 16'(y);
        b.sample_z = 16'(z);
        b.sample_w = 16'(w);
        send(b);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
    endtask

    task automatic cfg_ref(int x, int y, int z, int w);
        cfg_write(REG_REF_X, {4'($urandom), 16'(x)});
        cfg_write(REG_REF_Y, {4'($urandom), 16'(y)});
        cfg_write(REG_REF_Z, {4'($urandom), 16'(z)});
        cfg_write(REG_REF_W, {4'($urandom), 16'(w)});
    endtask

    task automatic cfg_end();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 0;
            end else if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
                stall = idle_len();
            end
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) sb.check_result(o_out);
        end
    end

    initial begin
        int r;
        sb = new();
        calm = 0;
        hold_req = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_in = '0;
        i_out_ready = 0;
        i_cfg_we = 0;
        i_cfg_idx = REG_WAIT;
        i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        cfg_write(REG_WAIT, 20'd3);
        cfg_end();

        // A tick before any sample is dropped; the first sample only starts the wait.
        send_tick();
        send_sample(100, -200, 300, 16000);
        send_sample(0, 0, 0, 16384);
        repeat (3) send_tick();
        send_sample(1200, -800, 5000, 15000);
        send_sample(0, 0, 0, 0);
        send_sample(-32768, -32768, -32768, -32768);
        send_sample(32767, 32767, 32767, 32767);
        send_sample(32767, -32768, 0, 1);
        send_sample(16384, 0, 0, 0);
        send_sample(0, -16384, 0, 0);
        send_sample(0, 0, 16384, 0);
        send_sample(0, 0, 0, -16384);
        send_sample(1, 0, 0, 0);
        send_sample(-1, -1, -1, -1);
        send_tick();
        send_sample(11585, 0, 0, 11585);
        settle();

        // Registers no longer matter once calibrated, but every one gets exercised.
        cfg_write(REG_WAIT, 20'd0);
        cfg_ref(-16384, 16384, -16384, 16384);
        cfg_write(REG_SPARE_LO, 20'hFFFFF);
        cfg_write(REG_SPARE_HI, 20'h12345);
        cfg_end();
        send_sample(2000, 3000, -4000, 12000);
        send_sample(-9000, 0, 9000, -9000);
        settle();

        cfg_write(REG_WAIT, 20'hFFFFF);
        cfg_ref(0, 0, 0, 0);
        cfg_end();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0) calm = ($urandom_range(0, 3) == 0);
            if (n == 300) hold_req = 1;
            if (n == 400) begin
                settle();
                cfg_write(REG_WAIT, 20'($urandom));
                cfg_ref($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                        $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);
                cfg_end();
            end
            r = $urandom_range(0, 9);
            if (r < 2) send_tick();
            else if (r < 7)
                send_sample($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                            $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);
            else
                send_sample($urandom, $urandom, $urandom, $urandom);
        end
        settle();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

>>> sim.f
hdl/iqoc_pkg.sv
hdl/iqoc_norm.sv
hdl/imu_quaternion_offset_calibrate_top.sv
tb/tb_imu_quaternion_offset_calibrate_top.sv
